// ===== design/ide_pkg.sv =====
// shared types, codes and constants for the input debounce edge latch
package ide_pkg;

  localparam int MAX_BANK      = 32;
  localparam int CHANNELS_DEF  = 16;
  localparam int KIND_W        = 3;
  localparam int CHAN_W        = 5;
  localparam int WIDTH_W       = 8;

  localparam logic [WIDTH_W-1:0] RESET_WIDTH = 8'd20;

  localparam logic [KIND_W-1:0] KIND_SAMPLE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TICK     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RD_RISE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RD_FALL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLR_EDGE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SET_WID  = 3'd5;

  // command as seen by one lane
  typedef struct packed {
    logic               en;
    logic [KIND_W-1:0]  kind;
    logic               sel;
    logic [WIDTH_W-1:0] width;
  } lane_cmd_t;

  // post-item state of one lane
  typedef struct packed {
    logic level;
    logic rise;
    logic fall;
    logic seen;
  } lane_out_t;

endpackage

// ===== design/ide_if.sv =====
// valid/ready channel interfaces for items and results
interface ide_in_if;
  logic                         valid;
  logic                         ready;
  logic [ide_pkg::KIND_W-1:0]   kind;
  logic [ide_pkg::MAX_BANK-1:0] pins;
  logic [ide_pkg::CHAN_W-1:0]   channel;
  logic [ide_pkg::WIDTH_W-1:0]  pulse_time;

  modport source (output valid, kind, pins, channel, pulse_time, input ready);
  modport sink (input valid, kind, pins, channel, pulse_time, output ready);
endinterface

interface ide_out_if;
  logic                         valid;
  logic                         ready;
  logic [ide_pkg::MAX_BANK-1:0] level_bits;
  logic [ide_pkg::MAX_BANK-1:0] rise_bits;
  logic [ide_pkg::MAX_BANK-1:0] fall_bits;
  logic                         edge_seen;

  modport source (output valid, level_bits, rise_bits, fall_bits, edge_seen, input ready);
  modport sink (input valid, level_bits, rise_bits, fall_bits, edge_seen, output ready);
endinterface

// ===== design/ide_lane.sv =====
// one debounce channel: pin history, hold counter, level and edge flags
module ide_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  ide_pkg::lane_cmd_t cmd_i,
  input  logic               pin_i,
  output ide_pkg::lane_out_t out_o
);

  logic                         level_r, level_nxt;
  logic                         rise_r, rise_nxt;
  logic                         fall_r, fall_nxt;
  logic                         last_r, last_nxt;
  logic [ide_pkg::WIDTH_W-1:0]  hold_r, hold_nxt;
  logic [ide_pkg::WIDTH_W-1:0]  minw_r, minw_nxt;
  logic                         seen;

  always_comb begin
    level_nxt = level_r;
    rise_nxt  = rise_r;
    fall_nxt  = fall_r;
    last_nxt  = last_r;
    hold_nxt  = hold_r;
    minw_nxt  = minw_r;
    seen      = 1'b0;
    case (cmd_i.kind)
      ide_pkg::KIND_SAMPLE: begin
        if (pin_i != last_r) begin
          last_nxt = pin_i;
          hold_nxt = minw_r;
        end else if (hold_r == '0) begin
          // pin low means active
          if (pin_i) begin
            if (level_r) begin
              fall_nxt = 1'b1;
              rise_nxt = 1'b0;
            end
            level_nxt = 1'b0;
          end else begin
            if (!level_r) begin
              rise_nxt = 1'b1;
              fall_nxt = 1'b0;
            end
            level_nxt = 1'b1;
          end
        end
      end
      ide_pkg::KIND_TICK: begin
        if (hold_r != '0) hold_nxt = hold_r - 1'b1;
      end
      ide_pkg::KIND_RD_RISE: begin
        if (cmd_i.sel) begin
          seen     = rise_r;
          rise_nxt = 1'b0;
        end
      end
      ide_pkg::KIND_RD_FALL: begin
        if (cmd_i.sel) begin
          seen     = fall_r;
          fall_nxt = 1'b0;
        end
      end
      ide_pkg::KIND_CLR_EDGE: begin
        if (cmd_i.sel) begin
          rise_nxt = 1'b0;
          fall_nxt = 1'b0;
        end
      end
      ide_pkg::KIND_SET_WID: begin
        if (cmd_i.sel) begin
          hold_nxt = cmd_i.width;
          minw_nxt = cmd_i.width;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b0;
      rise_r  <= 1'b0;
      fall_r  <= 1'b0;
      last_r  <= 1'b0;
      hold_r  <= ide_pkg::RESET_WIDTH;
      minw_r  <= ide_pkg::RESET_WIDTH;
    end else if (cmd_i.en) begin
      level_r <= level_nxt;
      rise_r  <= rise_nxt;
      fall_r  <= fall_nxt;
      last_r  <= last_nxt;
      hold_r  <= hold_nxt;
      minw_r  <= minw_nxt;
    end
  end

  assign out_o = '{level: level_nxt, rise: rise_nxt, fall: fall_nxt, seen: seen};

endmodule

// ===== design/ide_merge.sv =====
// gathers lane results into bit vectors and holds them in the result register
module ide_merge #(
  parameter int CHANNELS = ide_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         load_i,
  input  ide_pkg::lane_out_t           lanes_i [CHANNELS],
  output logic [ide_pkg::MAX_BANK-1:0] level_o,
  output logic [ide_pkg::MAX_BANK-1:0] rise_o,
  output logic [ide_pkg::MAX_BANK-1:0] fall_o,
  output logic                         seen_o
);

  logic [ide_pkg::MAX_BANK-1:0] level_nxt, rise_nxt, fall_nxt;
  logic                         seen_nxt;
  logic [ide_pkg::MAX_BANK-1:0] level_r, rise_r, fall_r;
  logic                         seen_r;

  always_comb begin
    level_nxt = '0;
    rise_nxt  = '0;
    fall_nxt  = '0;
    seen_nxt  = 1'b0;
    // at most one lane is selected, so an or of seen bits is exact
    for (int i = 0; i < CHANNELS; i++) begin
      level_nxt[i] = lanes_i[i].level;
      rise_nxt[i]  = lanes_i[i].rise;
      fall_nxt[i]  = lanes_i[i].fall;
      seen_nxt     = seen_nxt | lanes_i[i].seen;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      level_r <= level_nxt;
      rise_r  <= rise_nxt;
      fall_r  <= fall_nxt;
      seen_r  <= seen_nxt;
    end
  end

  assign level_o = level_r;
  assign rise_o  = rise_r;
  assign fall_o  = fall_r;
  assign seen_o  = seen_r;

endmodule

// ===== design/input_debounce_edge_latch.sv =====
// top level of the multi-channel debouncer with sticky edge latches
// The result of every accepted item appears in the output register on the next cycle,
// so a new item is accepted every cycle while the result side keeps up; in_ch
// ready drops only while a result waits and out_ch ready is low. Each of the CHANNELS lanes
// updates its own counter and flags in parallel; a merge stage packs the lane states into
// the level, rise and fall vectors (bits at or above CHANNELS read zero) and picks the
// flag read by a read rising or read falling item. An out-of-range channel index selects no lane.
module input_debounce_edge_latch #(
  parameter int CHANNELS = ide_pkg::CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ide_in_if.sink     in_ch,
  ide_out_if.source  out_ch
);

  logic                out_valid_r;
  logic                in_xfer;
  ide_pkg::lane_out_t  lane_out [CHANNELS];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    ide_pkg::lane_cmd_t cmd;
    assign cmd.en    = in_xfer;
    assign cmd.kind  = in_ch.kind;
    assign cmd.sel   = (in_ch.channel == ide_pkg::CHAN_W'(g));
    assign cmd.width = in_ch.pulse_time;

    ide_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd_i (cmd),
      .pin_i (in_ch.pins[g]),
      .out_o (lane_out[g])
    );
  end

  ide_merge #(.CHANNELS(CHANNELS)) u_merge (
    .clk     (clk),
    .load_i  (in_xfer),
    .lanes_i (lane_out),
    .level_o (out_ch.level_bits),
    .rise_o  (out_ch.rise_bits),
    .fall_o  (out_ch.fall_bits),
    .seen_o  (out_ch.edge_seen)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid = out_valid_r;

  // an accepted item always produces a result next cycle
  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_ch.valid)
    else $error("accepted item produced no result");

  // a channel never holds both a pending rise and a pending fall
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.rise_bits & out_ch.fall_bits) == '0))
    else $error("rise and fall pending on the same channel");

  if (CHANNELS < ide_pkg::MAX_BANK) begin : g_unused_chk
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_ch.valid |-> (out_ch.level_bits[ide_pkg::MAX_BANK-1:CHANNELS] == '0 &&
                        out_ch.rise_bits[ide_pkg::MAX_BANK-1:CHANNELS] == '0 &&
                        out_ch.fall_bits[ide_pkg::MAX_BANK-1:CHANNELS] == '0))
      else $error("bits beyond the bank are set");
  end

endmodule
